>>> hw/rtl/uvs_pkg.sv
// uvs_pkg: shared types and constants for the unique value stack
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package uvs_pkg;

    // stack geometry
    localparam int DEPTH   = 16;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    // word returned by pop or peek on an empty stack
    localparam logic signed [WORD_W-1:0] EMPTY_WORD = '1;

    // request codes
    typedef enum logic [2:0] {
        REQ_PUSH   = 3'd0,
        REQ_POP    = 3'd1,
        REQ_PEEK   = 3'd2,
        REQ_PUSHU  = 3'd3,
        REQ_REMOVE = 3'd4
    } req_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_MISS  = 2'd3
    } status_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic shift_down;   // push: each cell takes its upper neighbor's word, cell 0 the pushed word
        logic shift_up;     // pop: each cell takes its lower neighbor's word, the bottom cell keeps its own
        logic remove;       // remove: cells at or below the first match shift up
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/unique_value_stack_core.sv
// unique_value_stack_core: bounded stack with unique push and remove
// depends on uvs_pkg and uvs_cell
//
// usage
//   input channel s_valid/s_ready carries one request word: s_req_type and
//   s_data_in (push, pop, peek, push unique, remove topmost match)
//   result channel m_valid/m_ready carries one word per request: m_data_out,
//   m_status and m_count (words held after the request)
//   the stack is a row of DEPTH cells with the top in cell 0; every cell
//   compares its word with s_data_in and hands its word to a neighbor in the
//   same cycle, so a request is fully executed in the cycle it is accepted
//   result: the result word is registered and is valid in the cycle after the request is accepted
//   throughput: one request per cycle while the result is not stalled, set by the cell shift
//   and the match chain that runs through all cells
//   stall: the result register holds its word while m_ready is low; s_ready
//   is high whenever the result register is empty or is being drained
//   reset: aresetn low clears the count and the result valid; cell contents
//   are undefined until pushed and are never read above the count
`timescale 1ns / 1ps
`default_nettype none

module unique_value_stack_core
    import uvs_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [2:0]                s_req_type,
    input  wire logic signed [WORD_W-1:0]  s_data_in,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic signed [WORD_W-1:0]       m_data_out,
    output logic [1:0]                     m_status,
    output logic [COUNT_W-1:0]             m_count
);

    logic [COUNT_W-1:0]        count_reg;
    logic [COUNT_W-1:0]        count_next;
    logic                      m_valid_reg;
    logic signed [WORD_W-1:0]  data_reg;
    logic signed [WORD_W-1:0]  data_next;
    status_t                   status_reg;
    status_t                   status_next;

    cell_ctrl_t                ctrl;
    logic                      s_fire;
    logic                      full;
    logic                      empty;
    logic                      any_match;

    logic signed [WORD_W-1:0]  cell_word [DEPTH];
    logic                      seen      [DEPTH+1];
    logic [DEPTH-1:0]          occ;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign full    = (count_reg == COUNT_W'(DEPTH));
    assign empty   = (count_reg == '0);

    // cell chain, top of stack in cell 0
    assign seen[0] = 1'b0;
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic signed [WORD_W-1:0] prev_w;
            logic signed [WORD_W-1:0] next_w;

            assign occ[gi] = (COUNT_W'(gi) < count_reg);

            if (gi == 0) begin : g_top
                assign prev_w = s_data_in;
            end else begin : g_mid
                assign prev_w = cell_word[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_bot
                assign next_w = cell_word[gi];
            end else begin : g_up
                assign next_w = cell_word[gi+1];
            end

            uvs_cell u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .occ       (occ[gi]),
                .key       (s_data_in),
                .prev_word (prev_w),
                .next_word (next_w),
                .seen_in   (seen[gi]),
                .seen_out  (seen[gi+1]),
                .word      (cell_word[gi])
            );
        end
    endgenerate

    assign any_match = seen[DEPTH];

    // request decode
    always_comb begin
        ctrl        = '0;
        count_next  = count_reg;
        data_next   = '0;
        status_next = ST_DONE;
        case (req_t'(s_req_type))
            REQ_PUSH: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    ctrl.shift_down = s_fire;
                    count_next      = count_reg + 1'b1;
                end
            end
            REQ_POP: begin
                if (empty) begin
                    data_next   = EMPTY_WORD;
                    status_next = ST_EMPTY;
                end else begin
                    data_next      = cell_word[0];
                    ctrl.shift_up  = s_fire;
                    count_next     = count_reg - 1'b1;
                end
            end
            REQ_PEEK: begin
                if (empty) begin
                    data_next   = EMPTY_WORD;
                    status_next = ST_EMPTY;
                end else begin
                    data_next = cell_word[0];
                end
            end
            REQ_PUSHU: begin
                if (full) begin
                    status_next = ST_FULL;
                end else if (any_match) begin
                    status_next = ST_MISS;
                end else begin
                    ctrl.shift_down = s_fire;
                    count_next      = count_reg + 1'b1;
                end
            end
            REQ_REMOVE: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else if (!any_match) begin
                    status_next = ST_MISS;
                end else begin
                    ctrl.remove = s_fire;
                    count_next  = count_reg - 1'b1;
                end
            end
            default: begin
                status_next = ST_DONE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result word register
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            data_reg   <= data_next;
            status_reg <= status_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_data_out = data_reg;
    assign m_status   = status_reg;
    assign m_count    = count_reg;

endmodule

`default_nettype wire

>>> hw/rtl/uvs_cell.sv
// uvs_cell: one stack slot of the unique value stack cell chain
// depends on uvs_pkg (cell_ctrl_t, WORD_W)
`timescale 1ns / 1ps
`default_nettype none

module uvs_cell
    import uvs_pkg::*;
(
    input  wire logic                     aclk,
    input  wire cell_ctrl_t               ctrl,
    input  wire logic                     occ,
    input  wire logic signed [WORD_W-1:0] key,
    input  wire logic signed [WORD_W-1:0] prev_word,
    input  wire logic signed [WORD_W-1:0] next_word,
    input  wire logic                     seen_in,
    output logic                          seen_out,
    output logic signed [WORD_W-1:0]      word
);

    logic signed [WORD_W-1:0] word_reg;
    logic signed [WORD_W-1:0] word_next;
    logic                     match;

    // compare against the search word; chain marks first match toward the top
    assign match    = occ && (word_reg == key);
    assign seen_out = seen_in || match;
    assign word     = word_reg;

    // neighbor hand-off
    always_comb begin
        if (ctrl.shift_down) begin
            word_next = prev_word;
        end else if (ctrl.shift_up || (ctrl.remove && seen_out)) begin
            word_next = next_word;
        end else begin
            word_next = word_reg;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/uvs_checker.sv
// uvs_checker: port-level assertions for unique_value_stack_core
// depends on uvs_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps
`default_nettype none

module uvs_checker
    import uvs_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    input  wire logic                      s_ready,
    input  wire logic                      m_valid,
    input  wire logic                      m_ready,
    input  wire logic signed [WORD_W-1:0]  m_data_out,
    input  wire logic [1:0]                m_status,
    input  wire logic [COUNT_W-1:0]        m_count
);

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data_out) && $stable(m_status)
            && $stable(m_count))
        else $error("stalled result word changed");

    // a stalled result blocks new requests
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("request taken while result stalled");

    // an accepted request word yields a result word on the next cycle
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("no result word after accepted request");

    // empty status only with nothing held
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_EMPTY |-> m_count == '0)
        else $error("empty status with words held");

    // full status only with every cell held
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_FULL |-> m_count == COUNT_W'(DEPTH))
        else $error("full status below depth");

endmodule

bind unique_value_stack_core uvs_checker u_uvs_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_data_out (m_data_out),
    .m_status   (m_status),
    .m_count    (m_count)
);

`default_nettype wire

>>> test/unique_value_stack_core_tb.sv
// unique_value_stack_core_tb: self-checking bench for the unique value stack core
// depends on uvs_pkg and unique_value_stack_core; runs a directed table, then
// random request traffic under several idle/stall phases against a local predictor
`timescale 1ns / 1ps

module unique_value_stack_core_tb;
    import uvs_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 12;
    localparam int RAND_ITEMS   = 1500;
    localparam int NUM_PHASES   = 4;
    localparam int POOL_SIZE    = 8;
    localparam int N_DIRECTED   = 28;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_MAX   = 10;

    // request codes the block leaves unused
    localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic signed [WORD_W-1:0] data;
        logic [1:0]               status;
        logic [COUNT_W-1:0]       count;
    } result_t;

    typedef struct packed {
        logic [2:0]               req;
        logic signed [WORD_W-1:0] word;
        logic                     typed;
        logic signed [WORD_W-1:0] data;
        logic [1:0]               status;
        logic [COUNT_W-1:0]       count;
    } stim_row_t;

    logic                      aclk       = 1'b0;
    logic                      aresetn    = 1'b0;
    logic                      s_valid    = 1'b0;
    logic                      s_ready;
    logic [2:0]                s_req_type = '0;
    logic signed [WORD_W-1:0]  s_data_in  = '0;
    logic                      m_valid;
    logic                      m_ready    = 1'b0;
    logic signed [WORD_W-1:0]  m_data_out;
    logic [1:0]                m_status;
    logic [COUNT_W-1:0]        m_count;

    // predicted stack contents, bottom first
    logic signed [WORD_W-1:0]  stack_words [DEPTH];
    int                        stack_fill = 0;

    result_t                   expected_results [$];
    stim_row_t                 directed_rows [N_DIRECTED];
    int                        src_idle_pct  = 0;
    int                        sink_stall_pct = 0;
    int                        error_count   = 0;
    int                        results_seen  = 0;
    int                        requests_sent = 0;
    int                        status_seen [4] = '{0, 0, 0, 0};
    int                        cycle_count   = 0;

    unique_value_stack_core DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_data_in  (s_data_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data_out (m_data_out),
        .m_status   (m_status),
        .m_count    (m_count)
    );

    // clock
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // index of the topmost held word equal to w, -1 when none
    function automatic int find_topmost(input logic signed [WORD_W-1:0] w);
        for (int i = stack_fill - 1; i >= 0; i--) begin
            if (stack_words[i] == w) return i;
        end
        return -1;
    endfunction

    // apply one request to the predicted stack and return its result
    function automatic result_t apply_request(input logic [2:0] req,
                                              input logic signed [WORD_W-1:0] w);
        result_t r;
        int      pos;
        r = '0;
        r.status = ST_DONE;
        case (req)
            REQ_PUSH: begin
                if (stack_fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    stack_words[stack_fill] = w;
                    stack_fill++;
                end
            end
            REQ_POP: begin
                if (stack_fill == 0) begin
                    r.data   = EMPTY_WORD;
                    r.status = ST_EMPTY;
                end else begin
                    stack_fill--;
                    r.data = stack_words[stack_fill];
                end
            end
            REQ_PEEK: begin
                if (stack_fill == 0) begin
                    r.data   = EMPTY_WORD;
                    r.status = ST_EMPTY;
                end else begin
                    r.data = stack_words[stack_fill - 1];
                end
            end
            REQ_PUSHU: begin
                if (stack_fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else if (find_topmost(w) >= 0) begin
                    r.status = ST_MISS;
                end else begin
                    stack_words[stack_fill] = w;
                    stack_fill++;
                end
            end
            REQ_REMOVE: begin
                if (stack_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    pos = find_topmost(w);
                    if (pos < 0) begin
                        r.status = ST_MISS;
                    end else begin
                        // close the gap, order of the rest kept
                        for (int j = pos; j < stack_fill - 1; j++) begin
                            stack_words[j] = stack_words[j + 1];
                        end
                        stack_fill--;
                    end
                end
            end
            default: ;
        endcase
        r.count = COUNT_W'(stack_fill);
        return r;
    endfunction

    // offer one request word, wait for acceptance, then queue its expected result
    task automatic send_request(input logic [2:0] req, input logic signed [WORD_W-1:0] w,
                                input logic typed, input result_t typed_res);
        result_t predicted;
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_data_in  <= w;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_request(req, w);
        expected_results.push_back(typed ? typed_res : predicted);
        requests_sent++;
    endtask

    // result side: check each accepted word, then pick the next ready level
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            status_seen[m_status]++;
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_MAX)
                    $display("unexpected result: data %0d status %0d count %0d",
                             m_data_out, m_status, m_count);
            end else begin
                result_t exp_res;
                exp_res = expected_results.pop_front();
                if (m_data_out !== exp_res.data || m_status !== exp_res.status ||
                    m_count !== exp_res.count) begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display(
                            "mismatch %0d exp %0d/%0d/%0d got %0d/%0d/%0d (data/status/count)",
                            results_seen, exp_res.data, exp_res.status, exp_res.count,
                            m_data_out, m_status, m_count);
                end
            end
        end
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // stimulus
    initial begin
        logic signed [WORD_W-1:0] word_pool [POOL_SIZE];
        logic signed [WORD_W-1:0] w;
        logic [2:0]               req;
        result_t                  row_res;
        int                       pick;
        int                       run_left;
        bit                       filling;

        directed_rows = '{
            '{REQ_PEEK,        32'h0000_0000, 1'b1, EMPTY_WORD, ST_EMPTY, 0},
            '{REQ_POP,         32'h0000_0000, 1'b1, EMPTY_WORD, ST_EMPTY, 0},
            '{REQ_REMOVE,      32'h0000_0000, 1'b1, 0,          ST_EMPTY, 0},
            '{REQ_SPARE_FIRST, 32'h0000_0001, 1'b1, 0,          ST_DONE,  0},
            '{REQ_SPARE_LAST,  32'hFFFF_FFFF, 1'b1, 0,          ST_DONE,  0},
            '{REQ_PUSH,        32'h7FFF_FFFF, 1'b1, 0,          ST_DONE,  1},
            '{REQ_PUSH,        32'h8000_0000, 1'b1, 0,          ST_DONE,  2},
            '{REQ_PEEK,        32'h0000_0000, 1'b1, 32'h8000_0000, ST_DONE, 2},
            '{REQ_PUSHU,       32'h7FFF_FFFF, 1'b1, 0,          ST_MISS,  2},
            '{REQ_PUSH,        32'h7FFF_FFFF, 1'b1, 0,          ST_DONE,  3},
            '{REQ_PUSHU,       32'hFFFF_FFFF, 1'b0, 0, ST_DONE, 0},
            '{REQ_PUSHU,       32'h0000_0000, 1'b0, 0, ST_DONE, 0},
            '{REQ_PUSH,        32'h0000_0000, 1'b0, 0, ST_DONE, 0},
            '{REQ_PUSHU,       32'h0000_0001, 1'b0, 0, ST_DONE, 0},
            '{REQ_PUSHU,       32'h5555_5555, 1'b0, 0, ST_DONE, 0},
            '{REQ_PUSHU,       32'hAAAA_AAAA, 1'b0, 0, ST_DONE, 0},
            '{REQ_PUSH,        32'h0000_002A, 1'b0, 0, ST_DONE, 0},
            '{REQ_PUSH,        32'hFFFF_FFD6, 1'b0, 0, ST_DONE, 0},
            '{REQ_PUSHU,       32'h0001_0000, 1'b0, 0, ST_DONE, 0},
            '{REQ_PUSHU,       32'hFFFF_0000, 1'b0, 0, ST_DONE, 0},
            '{REQ_PUSHU,       32'h1234_5678, 1'b0, 0, ST_DONE, 0},
            '{REQ_PUSHU,       32'h0000_0007, 1'b0, 0, ST_DONE, 0},
            '{REQ_PUSHU,       32'hFFFF_FFF9, 1'b0, 0, ST_DONE, 0},
            '{REQ_PUSH,        32'h0000_0063, 1'b1, 0,          ST_FULL,  16},
            '{REQ_PUSHU,       32'h0000_0000, 1'b1, 0,          ST_FULL,  16},
            '{REQ_REMOVE,      32'h7FFF_FFFF, 1'b0, 0, ST_DONE, 0},
            '{REQ_REMOVE,      32'h0BAD_0BAD, 1'b1, 0,          ST_MISS,  15},
            '{REQ_POP,         32'h0000_0000, 1'b0, 0, ST_DONE, 0}
        };

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table: extremes, every request, full/empty/miss cases
        foreach (directed_rows[i]) begin
            row_res.data   = directed_rows[i].data;
            row_res.status = directed_rows[i].status;
            row_res.count  = directed_rows[i].count;
            send_request(directed_rows[i].req, directed_rows[i].word,
                         directed_rows[i].typed, row_res);
        end

        // small pool of words so unique pushes and removes hit often
        foreach (word_pool[i]) word_pool[i] = $urandom;
        word_pool[0] = 32'h7FFF_FFFF;
        word_pool[1] = 32'h8000_0000;
        word_pool[2] = EMPTY_WORD;
        word_pool[3] = '0;

        filling  = 1'b1;
        run_left = $urandom_range(60, 20);
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // no idling, sender idle, receiver stalling, both lightly
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 75; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 75; end
                default: begin src_idle_pct = 18; sink_stall_pct = 18; end
            endcase
            for (int n = 0; n < RAND_ITEMS / NUM_PHASES; n++) begin
                // alternate runs that lean toward filling and toward draining
                if (run_left == 0) begin
                    filling  = !filling;
                    run_left = $urandom_range(60, 20);
                end
                run_left--;
                pick = $urandom_range(99);
                if (pick < 3)
                    req = 3'($urandom_range(REQ_SPARE_LAST, REQ_SPARE_FIRST));
                else if (filling)
                    req = (pick < 45) ? REQ_PUSH : (pick < 75) ? REQ_PUSHU :
                          (pick < 82) ? REQ_POP  : (pick < 88) ? REQ_PEEK : REQ_REMOVE;
                else
                    req = (pick < 12) ? REQ_PUSH : (pick < 22) ? REQ_PUSHU :
                          (pick < 55) ? REQ_POP  : (pick < 65) ? REQ_PEEK : REQ_REMOVE;
                if ($urandom_range(99) < 2)
                    word_pool[$urandom_range(POOL_SIZE - 1, 4)] = $urandom;
                if ($urandom_range(99) < 70)
                    w = word_pool[$urandom_range(POOL_SIZE - 1)];
                else
                    w = $urandom;
                send_request(req, w, 1'b0, '0);
            end
        end
        s_valid <= 1'b0;

        // drain outstanding results, then a short quiet tail
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        error_count += expected_results.size();

        $display("sent %0d requests, checked %0d results over %0d idle/stall phases",
                 requests_sent, results_seen, NUM_PHASES);
        $display("status mix: done %0d, full %0d, empty %0d, duplicate/not found %0d",
                 status_seen[ST_DONE], status_seen[ST_FULL],
                 status_seen[ST_EMPTY], status_seen[ST_MISS]);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> unique_value_stack_core.f
hw/rtl/uvs_pkg.sv
hw/rtl/uvs_cell.sv
hw/rtl/unique_value_stack_core.sv
hw/rtl/uvs_checker.sv
test/unique_value_stack_core_tb.sv
